// ===== sv/pdv_pkg.sv =====
// pdv_pkg: shared widths, register indexes, divider request/response types
// and the constant multiply used by the velocity estimator.
// No dependencies.
package pdv_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned AXW       = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned TW        = 32;
  localparam int unsigned MIN_W     = 20;
  localparam int unsigned VV_W      = 48;
  localparam int unsigned MUL_IW    = 53;
  localparam int unsigned MUL_OW    = 67;
  localparam int unsigned USEC_SH   = 6;

  localparam int unsigned DIV_W     = 68;
  localparam int unsigned DVS_W     = 34;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_CYC   = DIV_W / DIV_STEP;
  localparam int unsigned CNT_W     = $clog2(DIV_CYC + 1);

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 2'd1;

  localparam logic [MIN_W-1:0] MIN_GAP_RST = 20'd1000;
  localparam logic [TW-1:0]    MAX_GAP_RST = 32'd500000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // 15625 = 2^14 - 2^10 + 2^8 + 2^3 + 1; 10^6 = 15625 << 6
  function automatic logic [MUL_OW-1:0] mul15625(input logic [MUL_IW-1:0] a);
    logic [MUL_OW-1:0] w;
    w = {{(MUL_OW-MUL_IW){1'b0}}, a};
    return (w << 14) - (w << 10) + (w << 8) + (w << 3) + w;
  endfunction

endpackage

// ===== sv/pdv_div.sv =====
// pdv_div: shared restoring divider, DIV_STEP quotient bits per cycle.
// Depends on pdv_pkg for widths and the request/response words.
module pdv_div
  import pdv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  always_comb begin
    logic [DVS_W:0] sh;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_STEP; k++) begin
      sh    = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        rem_d    = DVS_W'(sh - {1'b0, dvs_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = sh[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= quo_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

// ===== sv/position_difference_velocity.sv =====
// Finite-difference velocity estimator: one position word in, one velocity word out.
// An update runs the shared divider three times per axis; a gap at or above max_gap_us
// skips the divisions, and an invalid sample skips them and the commit. The next word is
// taken the cycle after the result is loaded. Async active-low reset clears the control,
// stored last-sample and output registers (not the captured input or divider datapath);
// min_gap_us resets to 1000 and max_gap_us to 500000.
module position_difference_velocity
  import pdv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 sample_good_i,
  input  logic [TW-1:0]        time_us_i,
  input  logic signed [TW-1:0] pos_x_i,
  input  logic signed [TW-1:0] pos_y_i,
  input  logic signed [TW-1:0] pos_z_i,
  input  logic [TW-1:0]        var_x_i,
  input  logic [TW-1:0]        var_y_i,
  input  logic [TW-1:0]        var_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_out_o,
  output logic                 update_made_o,
  output logic signed [TW-1:0] vel_x_o,
  output logic signed [TW-1:0] vel_y_o,
  output logic signed [TW-1:0] vel_z_o,
  output logic [VV_W-1:0]      vvar_x_o,
  output logic [VV_W-1:0]      vvar_y_o,
  output logic [VV_W-1:0]      vvar_z_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_GAP, ST_VEL_PREP, ST_VEL_GO, ST_VEL_WAIT,
    ST_VAR1_GO, ST_VAR1_WAIT, ST_VAR2_GO, ST_VAR2_WAIT, ST_COMMIT, ST_FINISH
  } state_e;

  state_e           state_q;
  logic [AXW-1:0]   ax_q;
  logic             good_q;
  logic [TW-1:0]    time_q;
  logic [TW-1:0]    pos_q [AXES];
  logic [TW-1:0]    var_q [AXES];
  logic [TW-1:0]    last_time_q;
  logic [TW-1:0]    last_pos_q [AXES];
  logic [TW-1:0]    last_var_q [AXES];
  logic [TW-1:0]    held_vel_q [AXES];
  logic [TW-1:0]    g_q;
  logic             neg_q;
  logic [TW:0]      mag_q;
  logic             res_status_q;
  logic             res_upd_q;
  logic [VV_W-1:0]  vvar_q [AXES];
  logic [MIN_W-1:0] min_gap_q;
  logic [TW-1:0]    max_gap_q;
  logic             out_valid_q;
  logic             out_status_q;
  logic             out_upd_q;
  logic [TW-1:0]    out_vel_q [AXES];
  logic [VV_W-1:0]  out_vvar_q [AXES];

  logic [TW-1:0]     in_pos [AXES];
  logic [TW-1:0]     in_var [AXES];
  logic [TW:0]       diff;
  logic [TW:0]       vsum;
  logic [TW-1:0]     gap_lo;
  logic [TW-1:0]     gap_clamped;
  logic [MUL_IW-1:0] mul_a;
  logic [MUL_OW-1:0] mul_p;
  logic [TW-1:0]     vel_sat;
  logic [VV_W-1:0]   vvar_sat;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_pos[0] = pos_x_i;
  assign in_pos[1] = pos_y_i;
  assign in_pos[2] = pos_z_i;
  assign in_var[0] = var_x_i;
  assign in_var[1] = var_y_i;
  assign in_var[2] = var_z_i;

  assign diff = {pos_q[ax_q][TW-1], pos_q[ax_q]} - {last_pos_q[ax_q][TW-1], last_pos_q[ax_q]};
  assign vsum = {1'b0, var_q[ax_q]} + {1'b0, last_var_q[ax_q]};

  assign gap_lo      = (min_gap_q == '0) ? TW'(1) : {{(TW-MIN_W){1'b0}}, min_gap_q};
  assign gap_clamped = (g_q < gap_lo) ? gap_lo : g_q;

  always_comb begin
    case (state_q)
      ST_VEL_GO:  mul_a = {{(MUL_IW-TW-1){1'b0}}, mag_q};
      ST_VAR1_GO: mul_a = {{(MUL_IW-TW-1){1'b0}}, vsum};
      ST_VAR2_GO: mul_a = div_rsp.quotient[MUL_IW-1:0];
      default:    mul_a = '0;
    endcase
  end

  assign mul_p = mul15625(mul_a);

  always_comb begin
    div_req.start = (state_q == ST_VEL_GO) || (state_q == ST_VAR1_GO) ||
                    (state_q == ST_VAR2_GO);
    case (state_q)
      ST_VEL_GO: begin
        div_req.dividend = DIV_W'({mul_p, {USEC_SH{1'b0}}}) + DIV_W'(g_q >> 1);
        div_req.divisor  = {{(DVS_W-TW){1'b0}}, g_q};
      end
      ST_VAR1_GO: begin
        div_req.dividend = DIV_W'({mul_p, {USEC_SH{1'b0}}});
        div_req.divisor  = {{(DVS_W-TW){1'b0}}, g_q};
      end
      default: begin
        div_req.dividend = DIV_W'(mul_p);
        div_req.divisor  = {g_q, 2'b00};
      end
    endcase
  end

  pdv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (neg_q) begin
      if (|div_rsp.quotient[DIV_W-1:TW-1]) vel_sat = {1'b1, {(TW-1){1'b0}}};
      else                                 vel_sat = TW'(-div_rsp.quotient[TW-1:0]);
    end else begin
      if (|div_rsp.quotient[DIV_W-1:TW-1]) vel_sat = {1'b0, {(TW-1){1'b1}}};
      else                                 vel_sat = div_rsp.quotient[TW-1:0];
    end
    if (|div_rsp.quotient[DIV_W-1:VV_W]) vvar_sat = '1;
    else                                 vvar_sat = div_rsp.quotient[VV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ax_q         <= '0;
      good_q       <= 1'b0;
      last_time_q  <= '0;
      min_gap_q    <= MIN_GAP_RST;
      max_gap_q    <= MAX_GAP_RST;
      res_status_q <= 1'b0;
      res_upd_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_upd_q    <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        last_pos_q[i] <= '0;
        last_var_q[i] <= '0;
        held_vel_q[i] <= '0;
        vvar_q[i]     <= '0;
        out_vel_q[i]  <= '0;
        out_vvar_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MIN_GAP: min_gap_q <= cfg_data_i[MIN_W-1:0];
          CFG_MAX_GAP: max_gap_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            good_q <= sample_good_i;
            time_q <= time_us_i;
            for (int i = 0; i < AXES; i++) begin
              pos_q[i] <= in_pos[i];
              var_q[i] <= in_var[i];
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_status_q <= 1'b0;
          res_upd_q    <= 1'b0;
          for (int i = 0; i < AXES; i++) begin
            vvar_q[i] <= '0;
          end
          if (good_q) begin
            g_q     <= time_q - last_time_q;
            state_q <= ST_GAP;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_GAP: begin
          if (g_q >= max_gap_q) begin
            state_q <= ST_COMMIT;
          end else begin
            g_q          <= gap_clamped;
            ax_q         <= '0;
            res_status_q <= 1'b1;
            res_upd_q    <= 1'b1;
            state_q      <= ST_VEL_PREP;
          end
        end
        ST_VEL_PREP: begin
          neg_q   <= diff[TW];
          mag_q   <= diff[TW] ? (TW+1)'(-diff) : diff;
          state_q <= ST_VEL_GO;
        end
        ST_VEL_GO: state_q <= ST_VEL_WAIT;
        ST_VEL_WAIT: begin
          if (div_rsp.done) begin
            held_vel_q[ax_q] <= vel_sat;
            state_q          <= ST_VAR1_GO;
          end
        end
        ST_VAR1_GO: state_q <= ST_VAR1_WAIT;
        ST_VAR1_WAIT: begin
          if (div_rsp.done) begin
            state_q <= ST_VAR2_GO;
          end
        end
        ST_VAR2_GO: state_q <= ST_VAR2_WAIT;
        ST_VAR2_WAIT: begin
          if (div_rsp.done) begin
            vvar_q[ax_q] <= vvar_sat;
            if (ax_q == AXW'(AXES - 1)) begin
              state_q <= ST_COMMIT;
            end else begin
              ax_q    <= ax_q + 1'b1;
              state_q <= ST_VEL_PREP;
            end
          end
        end
        ST_COMMIT: begin
          last_time_q <= time_q;
          for (int i = 0; i < AXES; i++) begin
            last_pos_q[i] <= pos_q[i];
            last_var_q[i] <= var_q[i];
          end
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_upd_q    <= res_upd_q;
            for (int i = 0; i < AXES; i++) begin
              out_vel_q[i]  <= held_vel_q[i];
              out_vvar_q[i] <= vvar_q[i];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_out_o  = out_status_q;
  assign update_made_o = out_upd_q;
  assign vel_x_o       = out_vel_q[0];
  assign vel_y_o       = out_vel_q[1];
  assign vel_z_o       = out_vel_q[2];
  assign vvar_x_o      = out_vvar_q[0];
  assign vvar_y_o      = out_vvar_q[1];
  assign vvar_z_o      = out_vvar_q[2];

  a_vvar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_upd_q) |->
      ((out_vvar_q[0] == '0) && (out_vvar_q[1] == '0) && (out_vvar_q[2] == '0)))
    else $error("velocity variance nonzero without update");

  a_upd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_upd_q) |-> out_status_q)
    else $error("update reported with status cleared");

  a_gap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_VEL_GO) || (state_q == ST_VAR1_GO) || (state_q == ST_VAR2_GO))
      |-> (g_q != '0))
    else $error("division issued with zero gap");

endmodule
